>>> rtl/bllca_pkg.sv
// bllca_pkg: shared widths, mode and result codes, and the sequencer state type
// for the binary-lifting lca engine
// no dependencies
package bllca_pkg;

  localparam int NODE_VW  = 10;  // node id field width
  localparam int DEPTH_W  = 10;  // depth field width
  localparam int CNT_W    = 11;  // node_count register width
  localparam int DIST_W   = 11;  // path distance width
  localparam int MODE_W   = 2;
  localparam int KIND_W   = 2;

  localparam int MAX_NODES_DEF   = 1024;
  localparam int LIFT_LEVELS_DEF = 10;
  localparam int RAM_AW_DEF      = 10;

  localparam logic [CNT_W-1:0] NODE_COUNT_RST = 11'd1024;

  localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BUILD = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LCA   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_KTH   = 2'd3;

  localparam logic [KIND_W-1:0] KIND_LCA   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_KTH   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_BUILD = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BLD_RD1,
    ST_BLD_RD2,
    ST_BLD_WR,
    ST_Q_DEP,
    ST_LIFT,
    ST_LIFT_CAP,
    ST_MATCH,
    ST_CMP_RD,
    ST_CMP_CAP,
    ST_PAR_RD,
    ST_PAR_CAP,
    ST_CDEP_CAP,
    ST_KTH,
    ST_KTH_CAP,
    ST_DONE
  } state_t;

endpackage

>>> rtl/bllca_if.sv
// bllca_in_if / bllca_out_if: valid/ready channels of the lca engine
// depends on bllca_pkg
interface bllca_in_if;
  logic                           valid;
  logic                           ready;
  logic [bllca_pkg::MODE_W-1:0]   mode;
  logic [bllca_pkg::NODE_VW-1:0]  node_a;
  logic [bllca_pkg::NODE_VW-1:0]  node_b;
  logic [bllca_pkg::NODE_VW-1:0]  parent_node;
  logic [bllca_pkg::DEPTH_W-1:0]  depth;
  logic [bllca_pkg::NODE_VW-1:0]  step_count;

  modport source (output valid, mode, node_a, node_b, parent_node, depth, step_count,
                  input ready);
  modport sink   (input valid, mode, node_a, node_b, parent_node, depth, step_count,
                  output ready);
endinterface

interface bllca_out_if;
  logic                           valid;
  logic                           ready;
  logic [bllca_pkg::KIND_W-1:0]   result_kind;
  logic [bllca_pkg::NODE_VW-1:0]  answer_node;
  logic [bllca_pkg::DIST_W-1:0]   path_distance;

  modport source (output valid, result_kind, answer_node, path_distance, input ready);
  modport sink   (input valid, result_kind, answer_node, path_distance, output ready);
endinterface

>>> rtl/binary_lifting_lca_engine_core.sv
// binary_lifting_lca_engine_core: top level, sequencer over the jump and level memories
// depends on bllca_pkg, bllca_if, bllca_ram
//
//  channel | direction | handshake          | payload
//  in_ch   | in        | valid/ready        | mode, node_a, node_b, parent_node, depth,
//          |           |                    | step_count
//  out_ch  | out       | valid/ready        | result_kind, answer_node, path_distance
//  cfg     | in        | cfg_we, no wait    | cfg_wdata = node_count
//
// load: no result. build: for every active node and every used lifting level above
// zero, three jump memory accesses (read, read, write) per entry.
// lca and kth: each taken lift costs a registered jump memory read.
// the result sits in an output register; a new item is taken while it waits.
// reset clears control only; memory contents are not cleared.
module binary_lifting_lca_engine_core #(
  parameter int MAX_NODES   = bllca_pkg::MAX_NODES_DEF,
  parameter int LIFT_LEVELS = bllca_pkg::LIFT_LEVELS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [bllca_pkg::CNT_W-1:0]   cfg_wdata,
  bllca_in_if.sink                      in_ch,
  bllca_out_if.source                   out_ch
);

  localparam int NODE_AW = $clog2(MAX_NODES);
  localparam int LEV_W   = (LIFT_LEVELS > 1) ? $clog2(LIFT_LEVELS) : 1;
  localparam int LC_W    = $clog2(LIFT_LEVELS + 1);
  localparam int JAW     = NODE_AW + LEV_W;
  localparam int NVW     = bllca_pkg::NODE_VW;
  localparam int DW      = bllca_pkg::DEPTH_W;
  localparam int CW      = bllca_pkg::CNT_W;

  function automatic logic in_range(input logic [NVW-1:0] n);
    return 32'(n) < MAX_NODES;
  endfunction

  function automatic logic [3:0] bit_len(input logic [CW-1:0] v);
    logic [3:0] len;
    len = '0;
    for (int i = 0; i < CW; i++) begin
      if (v[i]) len = 4'(i + 1);
    end
    return len;
  endfunction

  // configuration
  logic [CW-1:0]   node_count_r;
  logic [CW-1:0]   n_act;
  logic [3:0]      n_len;
  logic [LC_W-1:0] lev_cnt;
  logic [LEV_W-1:0] lev_top;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= bllca_pkg::NODE_COUNT_RST;
    end else if (cfg_we) begin
      node_count_r <= cfg_wdata;
    end
  end

  always_comb begin
    if (node_count_r == '0) begin
      n_act = CW'(1);
    end else if (32'(node_count_r) > MAX_NODES) begin
      n_act = CW'(MAX_NODES);
    end else begin
      n_act = node_count_r;
    end
  end

  assign n_len   = bit_len(n_act);
  assign lev_cnt = (32'(n_len) > LIFT_LEVELS) ? LC_W'(LIFT_LEVELS) : LC_W'(n_len);
  assign lev_top = LEV_W'(lev_cnt - 1'b1);

  // sequencer registers
  bllca_pkg::state_t state_r, state_nxt;
  logic [NVW-1:0]  a_r, a_nxt;
  logic [NVW-1:0]  b_r, b_nxt;
  logic [NVW-1:0]  x_r, x_nxt;
  logic [DW-1:0]   da_r, da_nxt;
  logic [DW-1:0]   db_r, db_nxt;
  logic [DW-1:0]   diff_r, diff_nxt;
  logic [LEV_W-1:0] lev_r, lev_nxt;
  logic [NVW-1:0]  k_r, k_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [bllca_pkg::KIND_W-1:0] kind_r, kind_nxt;
  logic [bllca_pkg::DIST_W-1:0] dist_r, dist_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic [bllca_pkg::KIND_W-1:0] out_kind_r, out_kind_nxt;
  logic [NVW-1:0]               out_node_r, out_node_nxt;
  logic [bllca_pkg::DIST_W-1:0] out_dist_r, out_dist_nxt;

  // memory ports
  logic           jmp_we;
  logic [JAW-1:0] jmp_waddr, jmp_raddr_a, jmp_raddr_b;
  logic [NVW-1:0] jmp_wdata, jmp_rdata_a, jmp_rdata_b;
  logic           lvl_we;
  logic [NODE_AW-1:0] lvl_waddr, lvl_raddr_a, lvl_raddr_b;
  logic [DW-1:0]  lvl_wdata, lvl_rdata_a, lvl_rdata_b;

  bllca_ram #(.AW(JAW), .DW(NVW)) u_jump (
    .clk     (clk),
    .we      (jmp_we),
    .waddr   (jmp_waddr),
    .wdata   (jmp_wdata),
    .raddr_a (jmp_raddr_a),
    .raddr_b (jmp_raddr_b),
    .rdata_a (jmp_rdata_a),
    .rdata_b (jmp_rdata_b)
  );

  bllca_ram #(.AW(NODE_AW), .DW(DW)) u_level (
    .clk     (clk),
    .we      (lvl_we),
    .waddr   (lvl_waddr),
    .wdata   (lvl_wdata),
    .raddr_a (lvl_raddr_a),
    .raddr_b (lvl_raddr_b),
    .rdata_a (lvl_rdata_a),
    .rdata_b (lvl_rdata_b)
  );

  // helpers for the combinational block
  logic [LEV_W-1:0] lev_dn;
  logic             last_lev;
  logic             w_ok;
  logic [DW-1:0]    w_val;
  logic [NVW-1:0]   hop_a, hop_b;
  logic [DW-1:0]    dep_a, dep_b;
  logic [CW-1:0]    dsum, dtwice;

  assign lev_dn   = lev_r - 1'b1;
  assign last_lev = (lev_r == lev_top);
  assign w_val    = DW'(1) << lev_r;
  assign w_ok     = (32'(lev_r) < DW) && (w_val <= diff_r);
  // a node beyond the tables is its own ancestor and has depth zero
  assign hop_a    = in_range(a_r) ? jmp_rdata_a : a_r;
  assign hop_b    = in_range(b_r) ? jmp_rdata_b : b_r;
  assign dep_a    = in_range(a_r) ? lvl_rdata_a : '0;
  assign dep_b    = in_range(b_r) ? lvl_rdata_b : '0;
  assign dsum     = {1'b0, da_r} + {1'b0, db_r};
  assign dtwice   = {dep_a, 1'b0};

  assign in_ch.ready = (state_r == bllca_pkg::ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    x_nxt         = x_r;
    da_nxt        = da_r;
    db_nxt        = db_r;
    diff_nxt      = diff_r;
    lev_nxt       = lev_r;
    k_nxt         = k_r;
    cnt_nxt       = cnt_r;
    kind_nxt      = kind_r;
    dist_nxt      = dist_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_kind_nxt  = out_kind_r;
    out_node_nxt  = out_node_r;
    out_dist_nxt  = out_dist_r;

    jmp_we      = 1'b0;
    jmp_waddr   = {NODE_AW'(in_ch.node_a), LEV_W'(0)};
    jmp_wdata   = in_ch.parent_node;
    jmp_raddr_a = {NODE_AW'(a_r), lev_r};
    jmp_raddr_b = {NODE_AW'(b_r), lev_r};
    lvl_we      = 1'b0;
    lvl_waddr   = NODE_AW'(in_ch.node_a);
    lvl_wdata   = in_ch.depth;

    case (state_r)
      bllca_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          case (in_ch.mode)
            bllca_pkg::MODE_LOAD: begin
              if (in_range(in_ch.node_a)) begin
                jmp_we = 1'b1;
                lvl_we = 1'b1;
              end
            end
            bllca_pkg::MODE_BUILD: begin
              a_nxt    = '0;
              kind_nxt = bllca_pkg::KIND_BUILD;
              dist_nxt = '0;
              lev_nxt  = LEV_W'(1);
              cnt_nxt  = '0;
              state_nxt = (lev_cnt > LC_W'(1)) ? bllca_pkg::ST_BLD_RD1 : bllca_pkg::ST_DONE;
            end
            bllca_pkg::MODE_LCA: begin
              a_nxt     = in_ch.node_a;
              b_nxt     = in_ch.node_b;
              state_nxt = bllca_pkg::ST_Q_DEP;
            end
            bllca_pkg::MODE_KTH: begin
              a_nxt     = in_ch.node_a;
              k_nxt     = in_ch.step_count;
              lev_nxt   = '0;
              kind_nxt  = bllca_pkg::KIND_KTH;
              dist_nxt  = '0;
              state_nxt = bllca_pkg::ST_KTH;
            end
            default: ;
          endcase
        end
      end

      // build: read ancestor 2^(j-1), then its ancestor 2^(j-1), write level j
      bllca_pkg::ST_BLD_RD1: begin
        jmp_raddr_a = {NODE_AW'(cnt_r), lev_dn};
        state_nxt   = bllca_pkg::ST_BLD_RD2;
      end
      bllca_pkg::ST_BLD_RD2: begin
        x_nxt       = jmp_rdata_a;
        jmp_raddr_a = {NODE_AW'(jmp_rdata_a), lev_dn};
        state_nxt   = bllca_pkg::ST_BLD_WR;
      end
      bllca_pkg::ST_BLD_WR: begin
        jmp_we    = 1'b1;
        jmp_waddr = {NODE_AW'(cnt_r), lev_r};
        jmp_wdata = in_range(x_r) ? jmp_rdata_a : x_r;
        state_nxt = bllca_pkg::ST_BLD_RD1;
        if (cnt_r == n_act - 1'b1) begin
          cnt_nxt = '0;
          if (last_lev) begin
            state_nxt = bllca_pkg::ST_DONE;
          end else begin
            lev_nxt = lev_r + 1'b1;
          end
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      // lca: deeper node goes to a
      bllca_pkg::ST_Q_DEP: begin
        da_nxt   = dep_a;
        db_nxt   = dep_b;
        kind_nxt = bllca_pkg::KIND_LCA;
        lev_nxt  = lev_top;
        if (dep_a < dep_b) begin
          a_nxt    = b_r;
          b_nxt    = a_r;
          diff_nxt = dep_b - dep_a;
        end else begin
          diff_nxt = dep_a - dep_b;
        end
        state_nxt = bllca_pkg::ST_LIFT;
      end
      bllca_pkg::ST_LIFT: begin
        if (w_ok) begin
          diff_nxt  = diff_r - w_val;
          state_nxt = bllca_pkg::ST_LIFT_CAP;
        end else if (lev_r == '0) begin
          state_nxt = bllca_pkg::ST_MATCH;
        end else begin
          lev_nxt = lev_dn;
        end
      end
      bllca_pkg::ST_LIFT_CAP: begin
        a_nxt = hop_a;
        if (lev_r == '0) begin
          state_nxt = bllca_pkg::ST_MATCH;
        end else begin
          lev_nxt   = lev_dn;
          state_nxt = bllca_pkg::ST_LIFT;
        end
      end
      bllca_pkg::ST_MATCH: begin
        if (a_r == b_r) begin
          state_nxt = bllca_pkg::ST_CDEP_CAP;
        end else begin
          lev_nxt   = lev_top;
          state_nxt = bllca_pkg::ST_CMP_RD;
        end
      end
      bllca_pkg::ST_CMP_RD: begin
        state_nxt = bllca_pkg::ST_CMP_CAP;
      end
      bllca_pkg::ST_CMP_CAP: begin
        if (hop_a != hop_b) begin
          a_nxt = hop_a;
          b_nxt = hop_b;
        end
        if (lev_r == '0) begin
          state_nxt = bllca_pkg::ST_PAR_RD;
        end else begin
          lev_nxt   = lev_dn;
          state_nxt = bllca_pkg::ST_CMP_RD;
        end
      end
      bllca_pkg::ST_PAR_RD: begin
        state_nxt = bllca_pkg::ST_PAR_CAP;
      end
      bllca_pkg::ST_PAR_CAP: begin
        a_nxt     = hop_a;
        state_nxt = bllca_pkg::ST_CDEP_CAP;
      end
      bllca_pkg::ST_CDEP_CAP: begin
        // negative path length clamps to zero
        dist_nxt  = (dsum > dtwice) ? (dsum - dtwice) : '0;
        state_nxt = bllca_pkg::ST_DONE;
      end

      // kth: climb for each set bit of k, low level first
      bllca_pkg::ST_KTH, bllca_pkg::ST_KTH_CAP: begin
        if (state_r == bllca_pkg::ST_KTH_CAP) begin
          a_nxt = hop_a;
        end
        if ((state_r == bllca_pkg::ST_KTH) && k_r[0]) begin
          state_nxt = bllca_pkg::ST_KTH_CAP;
        end else if (last_lev) begin
          state_nxt = bllca_pkg::ST_DONE;
        end else begin
          lev_nxt   = lev_r + 1'b1;
          k_nxt     = k_r >> 1;
          state_nxt = bllca_pkg::ST_KTH;
        end
      end

      bllca_pkg::ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = kind_r;
          out_node_nxt  = a_r;
          out_dist_nxt  = dist_r;
          state_nxt     = bllca_pkg::ST_IDLE;
        end
      end

      default: state_nxt = bllca_pkg::ST_IDLE;
    endcase
  end

  // level reads follow the node that a holds next, so the depth of the node
  // in a is ready while a holds it
  assign lvl_raddr_a = (state_r == bllca_pkg::ST_IDLE) ? NODE_AW'(in_ch.node_a)
                                                       : NODE_AW'(a_nxt);
  assign lvl_raddr_b = (state_r == bllca_pkg::ST_IDLE) ? NODE_AW'(in_ch.node_b)
                                                       : NODE_AW'(b_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bllca_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    x_r        <= x_nxt;
    da_r       <= da_nxt;
    db_r       <= db_nxt;
    diff_r     <= diff_nxt;
    lev_r      <= lev_nxt;
    k_r        <= k_nxt;
    cnt_r      <= cnt_nxt;
    kind_r     <= kind_nxt;
    dist_r     <= dist_nxt;
    out_kind_r <= out_kind_nxt;
    out_node_r <= out_node_nxt;
    out_dist_r <= out_dist_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.result_kind   = out_kind_r;
  assign out_ch.answer_node   = out_node_r;
  assign out_ch.path_distance = out_dist_r;

endmodule

>>> rtl/bllca_ram.sv
// bllca_ram: one write port, two registered read ports
// depends on bllca_pkg for default widths
module bllca_ram #(
  parameter int AW = bllca_pkg::RAM_AW_DEF,
  parameter int DW = bllca_pkg::NODE_VW
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr_a,
  input  logic [AW-1:0] raddr_b,
  output logic [DW-1:0] rdata_a,
  output logic [DW-1:0] rdata_b
);

  logic [DW-1:0] mem [0:(1<<AW)-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

>>> rtl/bllca_checker.sv
// bllca_checker: port-level checks of the lca engine, bound to the top level
// depends on bllca_pkg, binary_lifting_lca_engine_core
module bllca_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [bllca_pkg::MODE_W-1:0]  in_mode,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [bllca_pkg::KIND_W-1:0]  out_kind,
  input logic [bllca_pkg::NODE_VW-1:0] out_node,
  input logic [bllca_pkg::DIST_W-1:0]  out_dist
);

  // a stalled result is not withdrawn
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // build done carries no node and no distance
  a_build_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == bllca_pkg::KIND_BUILD) |-> (out_node == '0) && (out_dist == '0))
    else $error("build result with nonzero payload");

  // kth answers carry no distance
  a_kth_dist: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == bllca_pkg::KIND_KTH) |-> (out_dist == '0))
    else $error("kth result with nonzero distance");

  // any item other than a load keeps the block busy for the next cycle
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_mode != bllca_pkg::MODE_LOAD) |=> !in_ready)
    else $error("input taken while a query or build is in progress");

endmodule

bind binary_lifting_lca_engine_core bllca_checker u_bllca_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_mode   (in_ch.mode),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_kind  (out_ch.result_kind),
  .out_node  (out_ch.answer_node),
  .out_dist  (out_ch.path_distance)
);
